### design/binned_mean_with_missing_flag_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binned mean block
// Shared wrappers so every assertion has the same clocking and reset handling.
// ----------------------------------------------------------------------------
`ifndef BINNED_MEAN_WITH_MISSING_FLAG_TOP_MACROS_SVH
`define BINNED_MEAN_WITH_MISSING_FLAG_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BMMF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("binned mean assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BMMF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("binned mean assertion failed");

`endif

### design/bmmf_pkg.sv
// ----------------------------------------------------------------------------
// Binned mean package
// Types and fixed constants shared by the binned mean modules.
// ----------------------------------------------------------------------------
package bmmf_pkg;

  // Width of the bin size register and its value after reset.
  localparam int CFG_WIDTH = 16;
  localparam logic [CFG_WIDTH-1:0] BIN_LEN_RESET = 16'd1;

  // Status of a closed bin, handed from the accumulator to the sequencer.
  typedef struct packed {
    logic missing;
    logic last;
  } bin_flags_t;

endpackage

### design/bmmf_accum.sv
// ----------------------------------------------------------------------------
// Binned mean accumulator
// Holds the bin size register, the running sum, the sample count and the
// missing mark, and captures the totals of each bin as it closes.
// ----------------------------------------------------------------------------
module bmmf_accum
  import bmmf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [CFG_WIDTH-1:0]                cfg_data,
  input  logic                                in_accept,
  input  logic [SAMPLE_WIDTH-1:0]             sample,
  input  logic                                sample_missing,
  input  logic                                sample_last,
  output logic                                closing,
  output logic [SAMPLE_WIDTH+COUNT_WIDTH-1:0] close_sum,
  output logic [COUNT_WIDTH-1:0]              close_count,
  output bin_flags_t                          close_flags
);

  localparam int SUM_WIDTH = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [CFG_WIDTH-1:0]   bin_len;
  logic [SUM_WIDTH-1:0]   running_sum;
  logic [COUNT_WIDTH-1:0] samples_in_bin;
  logic                   saw_missing;

  logic [SUM_WIDTH-1:0]   sum_next;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   missing_next;
  logic [CFG_WIDTH-1:0]   limit;

  always_comb begin
    sum_next     = running_sum + {{COUNT_WIDTH{sample[SAMPLE_WIDTH-1]}}, sample};
    count_next   = samples_in_bin + 1'b1;
    missing_next = saw_missing | sample_missing;
    // A bin size of zero acts as one.
    limit        = (bin_len == '0) ? CFG_WIDTH'(1) : bin_len;
    closing      = in_accept &&
                   (sample_last ||
                    (CMP_WIDTH'(count_next) >= CMP_WIDTH'(limit)) ||
                    (count_next == COUNT_MAX));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_len        <= BIN_LEN_RESET;
      running_sum    <= '0;
      samples_in_bin <= '0;
      saw_missing    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        bin_len <= cfg_data;
      end
      if (closing) begin
        running_sum    <= '0;
        samples_in_bin <= '0;
        saw_missing    <= 1'b0;
      end else if (in_accept) begin
        running_sum    <= sum_next;
        samples_in_bin <= count_next;
        saw_missing    <= missing_next;
      end
    end
  end

  // Totals of the bin that just closed; held until the next bin closes.
  always_ff @(posedge clk) begin
    if (closing) begin
      close_sum           <= sum_next;
      close_count         <= count_next;
      close_flags.missing <= missing_next;
      close_flags.last    <= sample_last;
    end
  end

endmodule

### design/bmmf_div.sv
// ----------------------------------------------------------------------------
// Binned mean divider
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero. The divisor is a positive sample count.
// ----------------------------------------------------------------------------
module bmmf_div #(
  parameter int SUM_WIDTH   = 48,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SUM_WIDTH-1:0]   dividend,
  input  logic [COUNT_WIDTH-1:0] divisor,
  output logic                   busy,
  output logic [SUM_WIDTH-1:0]   quotient
);

  localparam int STEP_WIDTH = (SUM_WIDTH > 1) ? $clog2(SUM_WIDTH) : 1;
  localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(SUM_WIDTH - 1);

  logic [STEP_WIDTH-1:0]  step;
  logic                   neg;
  logic [SUM_WIDTH-1:0]   quo;
  logic [COUNT_WIDTH-1:0] rem;
  logic [COUNT_WIDTH-1:0] dvsr;

  logic [COUNT_WIDTH:0]   shifted;
  logic [COUNT_WIDTH+1:0] diff;
  logic                   fits;

  always_comb begin
    shifted = {rem, quo[SUM_WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, dvsr};
    fits    = !diff[COUNT_WIDTH+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[SUM_WIDTH-1];
      // Magnitude; the most negative sum maps to its unsigned magnitude.
      quo  <= dividend[SUM_WIDTH-1] ? (~dividend + 1'b1) : dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      quo <= {quo[SUM_WIDTH-2:0], fits};
      rem <= fits ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
    end
  end

  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

### design/binned_mean_with_missing_flag_top.sv
// ----------------------------------------------------------------------------
// Binned mean with missing flag
// Averages a stream of signed Q16.16 samples over bins of a set size.
// ----------------------------------------------------------------------------
// Samples arrive on the s_axis stream, one per transfer, and are summed into
// bins of the configured size (a bin size of zero acts as one). A bin also
// closes at a sample with tlast set, and when its count reaches
// 2^COUNT_WIDTH - 1. For each closed bin one transfer leaves on m_axis carrying
// the sum divided by the count, truncated toward zero; if any sample of the bin
// was missing, tuser is set and the mean is zero. tlast on the output marks the
// bin closed by an input tlast. Samples stream at one per cycle inside a bin.
// A sample that closes a bin that has no missing sample starts the shared
// divider, which produces one quotient bit per cycle; the next sample is taken
// only once the quotient has moved into the output register, and that move
// waits while the output is stalled. A bin flagged missing skips the divider
// and goes from ST_LOAD straight to ST_WAIT. The finished result sits in an
// output register, so new samples are accepted while it waits for m_axis. The
// bin size register is written through the cfg port, which is ready whenever
// the block is out of reset, and takes effect from the next sample on; write
// it only while idle.
// ----------------------------------------------------------------------------
module binned_mean_with_missing_flag_top
  import bmmf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // Configuration write channel: bin size.
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [CFG_WIDTH-1:0]                     cfg_data,
  // Sample stream.
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        s_axis_tdata,  // sample_value
  input  logic                                     s_axis_tuser,  // sample_missing
  input  logic                                     s_axis_tlast,  // end_of_vector
  // Bin result stream.
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        m_axis_tdata,  // bin_mean
  output logic                                     m_axis_tuser,  // bin_missing
  output logic                                     m_axis_tlast   // last_bin
);

  localparam int SUM_WIDTH  = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int DATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;  // taking samples
  localparam logic [1:0] ST_LOAD = 2'd1;  // a bin closed; divide unless missing
  localparam logic [1:0] ST_DIV  = 2'd2;  // divider running
  localparam logic [1:0] ST_WAIT = 2'd3;  // result ready for the output register

  logic [1:0] state;
  logic [1:0] state_next;

  logic                    in_accept;
  logic                    closing;
  logic [SUM_WIDTH-1:0]    close_sum;
  logic [COUNT_WIDTH-1:0]  close_count;
  bin_flags_t              close_flags;
  logic                    div_start;
  logic                    div_busy;
  logic [SUM_WIDTH-1:0]    quotient;

  logic                    out_load;
  logic [SAMPLE_WIDTH-1:0] out_mean;
  logic                    out_missing;
  logic                    out_last;

  // Neither input channel takes a transfer while reset is held.
  assign cfg_ready     = !rst;
  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  bmmf_accum #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_accum (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .in_accept      (in_accept),
    .sample         (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .sample_missing (s_axis_tuser),
    .sample_last    (s_axis_tlast),
    .closing        (closing),
    .close_sum      (close_sum),
    .close_count    (close_count),
    .close_flags    (close_flags)
  );

  // A bin flagged missing never needs its quotient.
  assign div_start = (state == ST_LOAD) && !close_flags.missing;

  bmmf_div #(
    .SUM_WIDTH   (SUM_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (close_sum),
    .divisor  (close_count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // The output register is free when empty or emptying in this cycle.
  assign out_load = (state == ST_WAIT) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (closing) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = close_flags.missing ? ST_WAIT : ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mean    <= close_flags.missing ? '0 : quotient[SAMPLE_WIDTH-1:0];
      out_missing <= close_flags.missing;
      out_last    <= close_flags.last;
    end
  end

  assign m_axis_tdata = DATA_WIDTH'(out_mean);
  assign m_axis_tuser = out_missing;
  assign m_axis_tlast = out_last;

endmodule

### design/bmmf_checker.sv
// ----------------------------------------------------------------------------
// Binned mean port checker
// Watches the top level ports for handshake and result rules over time.
// ----------------------------------------------------------------------------
`include "binned_mean_with_missing_flag_top_macros.svh"

module bmmf_checker #(
  parameter int SAMPLE_WIDTH = 32
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tlast,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input logic                              m_axis_tuser,
  input logic                              m_axis_tlast
);

  // A stalled result stays offered.
  `BMMF_ASSERT_NEXT(a_out_valid_holds, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // A stalled result keeps its payload.
  `BMMF_ASSERT_NEXT(a_out_data_holds, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // A bin flagged missing carries a zero mean.
  `BMMF_ASSERT_NOW(a_missing_mean_zero, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

  // A sample with tlast always closes a bin, so the next sample must wait.
  `BMMF_ASSERT_NEXT(a_last_closes_bin, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

endmodule

bind binned_mean_with_missing_flag_top bmmf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bmmf_checker (.*);

### tb/tb_binned_mean_with_missing_flag_top.sv
// ----------------------------------------------------------------------------
// Binned mean with missing flag testbench
// Streams Q16.16 samples into the block under random and directed traffic and
// checks every bin result against a cycle-free model of the averaging.
// ----------------------------------------------------------------------------
// The sender task drives one sample per call and, at the edge where the sample
// transfer takes place, runs it through the bin accumulator below. A closed bin
// pushes its expected mean and flags onto a queue. The checker pops that queue
// on every result transfer and compares the mean, the missing flag and the last
// flag. The bin size register is only rewritten once the queue is empty and the
// divider has had time to finish, so the model never sees a write mid-bin that
// the block would see differently.
// ----------------------------------------------------------------------------
module tb_binned_mean_with_missing_flag_top;
  import bmmf_pkg::*;

  // A closing sample with no missing value runs the divider and then the handoff
  // to the output register; this covers that with some margin.
  localparam int DRAIN_CYCLES = 64;
  // Longest quiet stretch allowed: the deliberate output hold-off is far
  // shorter than this.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;

  typedef struct {
    logic signed [31:0] mean;
    logic               missing;
    logic               last;
  } bin_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_WIDTH-1:0] cfg_data;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata;   // sample_value
  logic                 s_axis_tuser;   // sample_missing
  logic                 s_axis_tlast;   // end_of_vector
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;   // bin_mean
  logic                 m_axis_tuser;   // bin_missing
  logic                 m_axis_tlast;   // last_bin

  // State of the accumulator model.
  logic [CFG_WIDTH-1:0] bin_len_reg  = BIN_LEN_RESET;
  logic signed [47:0]   bin_sum      = '0;
  logic [15:0]          bin_count    = '0;
  logic                 bin_saw_missing = 1'b0;

  bin_result_t pending_bins[$];
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int          hold_off_left  = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;

  binned_mean_with_missing_flag_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Adds one accepted sample to the running bin. The value of a missing sample
  // is still summed; it cannot show up because a flagged bin reports zero.
  function automatic void accumulate_sample(input logic [31:0] value, input logic missing,
                                            input logic eov);
    logic [15:0]        limit;
    logic signed [48:0] divisor;
    logic signed [48:0] quotient;
    bin_result_t        closed;
    limit = (bin_len_reg == '0) ? 16'd1 : bin_len_reg;
    bin_sum = bin_sum + {{16{value[31]}}, value};
    bin_count = bin_count + 16'd1;
    bin_saw_missing = bin_saw_missing | missing;
    // A bin closes when full, at the end of a vector, or when the count hits
    // its ceiling; a lowered bin size closes an overfull bin at its next sample.
    if (eov || bin_count >= limit || bin_count == COUNT_LIMIT) begin
      closed.mean = '0;
      if (!bin_saw_missing) begin
        divisor = {33'd0, bin_count};
        quotient = bin_sum / divisor;
        closed.mean = quotient[31:0];
      end
      closed.missing = bin_saw_missing;
      closed.last = eov;
      pending_bins.insert(pending_bins.size(), closed);
      bin_sum = '0;
      bin_count = '0;
      bin_saw_missing = 1'b0;
    end
  endfunction

  // Mostly full-range values, with the extremes and small magnitudes mixed in
  // so that truncation toward zero shows up often.
  function automatic logic [31:0] random_value();
    logic [31:0] value;
    case ($urandom_range(9))
      0: value = 32'h7FFF_FFFF;
      1: value = 32'h8000_0000;
      2: value = 32'($urandom_range(200)) - 32'd100;
      default: value = $urandom;
    endcase
    return value;
  endfunction

  function automatic logic [CFG_WIDTH-1:0] pick_bin_len();
    logic [CFG_WIDTH-1:0] size;
    case ($urandom_range(15))
      0: size = '0;
      1: size = 16'd1;
      2: size = 16'hFFFF;
      3: size = CFG_WIDTH'($urandom_range(13, 100));
      default: size = CFG_WIDTH'($urandom_range(2, 12));
    endcase
    return size;
  endfunction

  // Offers one sample and returns at the edge of its transfer with tvalid
  // still high, so a back-to-back sample needs no second write to tvalid.
  task automatic send_sample(input logic [31:0] value, input logic missing, input logic eov);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= missing;
    s_axis_tlast  <= eov;
    do @(posedge clk); while (!s_axis_tready);
    accumulate_sample(value, missing, eov);
  endtask

  // Stops offering samples until every expected bin is out, then lets the
  // divider settle before anything else happens.
  task automatic drain_bins();
    s_axis_tvalid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bin_len(input logic [CFG_WIDTH-1:0] size);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bin_len_reg = size;
  endtask

  // Reset bin size of one: every sample is its own bin, so the extremes pass
  // straight through, and a missing sample with a nonzero value reports zero.
  task automatic test_extremes_default_size();
    send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_sample(32'h8000_0000, 1'b0, 1'b0);
    send_sample(32'h0000_0000, 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_sample(32'h0001_2345, 1'b1, 1'b1);
    send_sample(32'h0000_0001, 1'b0, 1'b1);
    drain_bins();
  endtask

  // A bin size of zero must behave as one.
  task automatic test_zero_bin_len();
    write_bin_len('0);
    send_sample(-32'sd3, 1'b0, 1'b0);
    send_sample(32'sd5, 1'b0, 1'b1);
    drain_bins();
  endtask

  // A short final bin with a negative sum that truncates toward zero, a full
  // bin of the largest value, and a full bin spoiled by one missing sample.
  task automatic test_partial_bin_truncation();
    write_bin_len(16'd4);
    send_sample(-32'sd7, 1'b0, 1'b0);
    send_sample(32'sd2, 1'b0, 1'b0);
    send_sample(32'sd0, 1'b0, 1'b1);
    repeat (4) send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_sample(32'h8000_0000, 1'b0, 1'b0);
    send_sample(32'h8000_0000, 1'b0, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_sample(32'sd5, 1'b0, 1'b0);
    drain_bins();
  endtask

  // Five samples into a bin of eight, then the size drops to three: the next
  // sample finds the count already past the new size and closes the bin.
  task automatic test_lowered_mid_bin();
    write_bin_len(16'd8);
    repeat (5) send_sample(random_value(), 1'b0, 1'b0);
    drain_bins();
    write_bin_len(16'd3);
    send_sample(random_value(), 1'b0, 1'b0);
    drain_bins();
  endtask

  // The receiver holds off for a long stretch while single-sample bins keep
  // coming, so the output register fills, the next result waits behind it and the input stalls.
  task automatic test_output_backpressure();
    write_bin_len(16'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (12) send_sample(random_value(), 1'b0, 1'b0);
    drain_bins();
  endtask

  // Mostly well-formed vectors that end in tlast and rarely carry a missing
  // sample; the rest are broken runs with stray tlast and many missing ones.
  task automatic test_random_vectors(input int n_items, input int send_pct, input int recv_pct);
    int   sent;
    int   vec_len;
    bit   broken;
    logic missing;
    logic eov;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(5) == 0) begin
        drain_bins();
        write_bin_len(pick_bin_len());
      end
      vec_len = $urandom_range(1, 40);
      broken = ($urandom_range(99) < 15);
      for (int i = 0; i < vec_len; i++) begin
        missing = broken ? ($urandom_range(3) == 0) : ($urandom_range(99) < 3);
        eov = broken ? ($urandom_range(7) == 0) : (i == vec_len - 1);
        send_sample(random_value(), missing, eov);
      end
      sent += vec_len;
    end
    drain_bins();
  endtask

  // The largest bin size with a run of the most negative value that only
  // tlast closes, so the sum lies far below the sample range.
  task automatic test_large_bin_len();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_bin_len(16'hFFFF);
    repeat (30) send_sample(32'h8000_0000, 1'b0, 1'b0);
    send_sample(random_value(), 1'b0, 1'b1);
    drain_bins();
  endtask

  // The receiver draws tready each cycle, except during a requested hold-off,
  // which it counts down itself.
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result transfer is compared against the oldest expected bin.
  always @(posedge clk) begin
    bin_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_bins.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected bin result: mean=%h missing=%b last=%b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
      end else begin
        want = pending_bins.pop_front();
        if (m_axis_tdata !== want.mean || m_axis_tuser !== want.missing ||
            m_axis_tlast !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("bin mismatch: mean exp=%h got=%h missing exp=%b got=%b last exp=%b got=%b",
                     want.mean, m_axis_tdata, want.missing, m_axis_tuser,
                     want.last, m_axis_tlast);
          end
        end
      end
    end
  end

  // The run ends here if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes_default_size();
    test_zero_bin_len();
    test_partial_bin_truncation();
    test_lowered_mid_bin();
    test_output_backpressure();
    test_random_vectors(600, 14, 71);
    test_random_vectors(600, 71, 14);
    test_random_vectors(600, 0, 0);
    test_large_bin_len();

    if (mismatch_count == 0 && pending_bins.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/bmmf_pkg.sv
design/bmmf_accum.sv
design/bmmf_div.sv
design/binned_mean_with_missing_flag_top.sv
design/bmmf_checker.sv
tb/tb_binned_mean_with_missing_flag_top.sv
